// ===== rtl/ovl_pkg.sv =====
package ovl_pkg;

  // Largest number of entries the list can hold.
  localparam int CAPACITY = 16;

  // Derived sizes: an address into the entry store, and a count that can
  // also hold CAPACITY itself.
  localparam int ADDR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Fixed field widths of the two channels.
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } ovl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    append_wr;
    logic    stream;
    logic    shift_wr;
    logic    take_hit;
    logic    count_dec;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } ovl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            match;
    logic            stream_done;
    logic            out_free;
  } ovl_sts_t;

endpackage

// ===== rtl/ovl_req_if.sv =====
interface ovl_req_if import ovl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

// ===== rtl/ovl_rsp_if.sv =====
interface ovl_rsp_if import ovl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [LEN_W-1:0]    length;

  modport source (output valid, output status, output position, output length, input ready);
  modport sink (input valid, input status, input position, input length, output ready);
endinterface

// ===== rtl/ovl_ctrl.sv =====
module ovl_ctrl import ovl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ovl_sts_t sts,
  output ovl_cmd_t cmd
);

  ovl_state_t state;
  ovl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_SEARCH, OP_REMOVE: state_next = S_SCAN;
          default:              state_next = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          state_next = (sts.op == OP_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (sts.stream_done) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (sts.stream_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.append_wr = 1'b0;
    cmd.stream    = 1'b0;
    cmd.shift_wr  = 1'b0;
    cmd.take_hit  = 1'b0;
    cmd.count_dec = 1'b0;
    cmd.res_set   = 1'b0;
    cmd.res_code  = ST_OK;
    cmd.out_load  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_APPEND: begin
            cmd.res_set = 1'b1;
            if (sts.full) begin
              cmd.res_code = ST_FULL;
            end else begin
              cmd.append_wr = 1'b1;
              cmd.res_code  = ST_OK;
            end
          end
          OP_SEARCH, OP_REMOVE: begin
            cmd.res_set = 1'b0;
          end
          default: begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_NOT_FOUND;
          end
        endcase
      end
      S_SCAN: begin
        cmd.stream = 1'b1;
        if (sts.match) begin
          cmd.take_hit = 1'b1;
          cmd.res_set  = (sts.op == OP_SEARCH);
          cmd.res_code = ST_OK;
        end else if (sts.stream_done) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end
      end
      S_SHIFT: begin
        cmd.stream   = 1'b1;
        cmd.shift_wr = 1'b1;
        if (sts.stream_done) begin
          cmd.count_dec = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_code  = ST_OK;
        end
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/ovl_dpath.sv =====
module ovl_dpath import ovl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ovl_cmd_t            cmd,
  output ovl_sts_t            sts,
  input  logic [OP_W-1:0]     req_operation,
  input  logic [VALUE_W-1:0]  req_value,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [STATUS_W-1:0] rsp_status,
  output logic [POS_W-1:0]    rsp_position,
  output logic [LEN_W-1:0]    rsp_length
);

  logic [VALUE_W-1:0]  mem [CAPACITY];
  logic [VALUE_W-1:0]  rd_data;
  logic                rd_vld;
  logic [ADDR_W-1:0]   rd_idx;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    count;
  logic [OP_W-1:0]     op;
  logic [VALUE_W-1:0]  val;
  logic [ADDR_W-1:0]   pos;
  status_t             res_status;
  logic                more;

  // More stored entries remain ahead of the read pointer.
  assign more = (idx < count);

  assign sts.op          = op;
  assign sts.full        = (count == CNT_W'(CAPACITY));
  assign sts.match       = rd_vld && (rd_data == val);
  assign sts.stream_done = !rd_vld && !more;
  assign sts.out_free    = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.append_wr) begin
        count <= count + 1'b1;
      end else if (cmd.count_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.load || cmd.take_hit) begin
        rd_vld <= 1'b0;
      end else if (cmd.stream) begin
        rd_vld <= more;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req_operation;
      val <= req_value;
      idx <= '0;
      pos <= '0;
    end
    if (cmd.stream) begin
      rd_idx <= idx[ADDR_W-1:0];
      if (more) begin
        idx <= idx + 1'b1;
      end
    end
    if (cmd.take_hit) begin
      idx <= CNT_W'(rd_idx) + 1'b1;
      pos <= rd_idx;
    end
    if (cmd.append_wr) begin
      pos <= count[ADDR_W-1:0];
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
    end
    if (cmd.out_load) begin
      rsp_status   <= res_status;
      rsp_position <= POS_W'(pos);
      rsp_length   <= LEN_W'(count);
    end
  end

  // Entry store: one write port (append or shift-down) and one registered read.
  always_ff @(posedge clk) begin
    if (cmd.append_wr) begin
      mem[count[ADDR_W-1:0]] <= val;
    end else if (cmd.shift_wr && rd_vld) begin
      mem[rd_idx - 1'b1] <= rd_data;
    end
    if (cmd.stream) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.append_wr |=> count == $past(count) + 1'b1)
    else $error("append did not grow the list by one");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_wr && rd_vld) |-> rd_idx != '0)
    else $error("shift write would go below the head");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result loaded over an untaken result");

endmodule

// ===== rtl/ordered_value_list_top.sv =====
// Ordered value list: keeps up to CAPACITY signed 32-bit values in insertion
// order. Each transaction on the req channel carries an operation (append,
// search, remove) and a value; each produces exactly one transaction on the
// rsp channel with a status, a position from the head and the list length
// after the operation. Both channels use a valid/ready handshake.
// The block works on one transaction at a time. After acceptance, append and
// unused operation codes pass through the dispatch and finish states before
// the request channel is ready again. Search and remove stream entries out
// of a single-port-read memory, one entry per cycle. A remove then moves
// every later entry one place toward the head through the same read port.
// The read port of the entry memory sets this rate. The result sits in an
// output register, so a new request is taken while an earlier result still
// waits; if the receiver stalls, the next result waits in the datapath
// while the controller holds in its finish state until the output register
// is free.
// Reset empties the list at once; there is no clearing pass, since entries
// are only read below the current length.
module ordered_value_list_top import ovl_pkg::*; (
  input logic       clk,
  input logic       rst,
  ovl_req_if.sink   req,
  ovl_rsp_if.source rsp
);

  ovl_cmd_t cmd;
  ovl_sts_t sts;

  // The controller sequences dispatch, the scan for a match, the shift that
  // closes the gap after a remove, and the hand-off to the output register.
  ovl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the entry memory, the length, the read pointer and
  // the result register that drives the response channel.
  ovl_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_operation (req.operation),
    .req_value     (req.value),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_position  (rsp.position),
    .rsp_length    (rsp.length)
  );

endmodule
